>>> src/integral_sliding_mode_force_control_defines.svh
// Assertion macros for the integral sliding-mode force controller.
// Used by the top level; the assertions sample clk_i and are disabled while rst_ni is low.
`ifndef INTEGRAL_SLIDING_MODE_FORCE_CONTROL_DEFINES_SVH
`define INTEGRAL_SLIDING_MODE_FORCE_CONTROL_DEFINES_SVH

`ifndef SYNTH

`define ISMFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ismfc check failed");

`define ISMFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ismfc check failed");

`else

`define ISMFC_ASSERT_IMP(lbl, ante, cons)

`define ISMFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> src/ismfc_pkg.sv
// Package of the integral sliding-mode force controller: widths, payload and
// configuration types, codes and saturation helpers. No dependencies.
`default_nettype none

package ismfc_pkg;

  localparam int DW        = 32;
  localparam int UW        = 31;
  localparam int FRAC      = 16;
  localparam int OPND_W    = DW + 1;
  localparam int PROD_W    = 2 * DW;
  localparam int WIDE_W    = DW + FRAC;
  localparam int ACC_W     = DW + 4;
  localparam int DIV_STEPS = WIDE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DW-1:0] q_t;
  typedef logic [UW-1:0]        uq_t;

  localparam q_t SMAX     = {1'b0, {(DW-1){1'b1}}};
  localparam q_t SMIN     = {1'b1, {(DW-1){1'b0}}};
  localparam q_t QONE     = q_t'(1 << FRAC);
  localparam q_t QNEG_ONE = q_t'(-(1 << FRAC));

  localparam logic signed [WIDE_W-1:0] WMAX = {{(WIDE_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WMIN = {{(WIDE_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [WIDE_W-1:0] ULIM_POS = {{(WIDE_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [WIDE_W-1:0] ULIM_NEG = {{(WIDE_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    q_t  torque_meas;
    q_t  torque_rate_meas;
    q_t  ref_force;
    q_t  ref_rate;
    q_t  ref_accel;
    uq_t time_step;
    q_t  load_accel;
  } in_item_t;

  typedef struct packed {
    q_t drive_out;
  } out_item_t;

  typedef struct packed {
    uq_t lambda_one;
    uq_t lambda_two;
    q_t  prop_gain;
    q_t  deriv_gain;
    q_t  inertia_ratio;
    uq_t boundary_width;
    q_t  switch_gain;
    q_t  accel_gain;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA_ONE     = 3'd0,
    CFG_LAMBDA_TWO     = 3'd1,
    CFG_PROP_GAIN      = 3'd2,
    CFG_DERIV_GAIN     = 3'd3,
    CFG_INERTIA_RATIO  = 3'd4,
    CFG_BOUNDARY_WIDTH = 3'd5,
    CFG_SWITCH_GAIN    = 3'd6,
    CFG_ACCEL_GAIN     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_CHK,
    S_DIVI,
    S_MUL,
    S_ACC,
    S_US,
    S_DIVU
  } state_e;

  typedef enum logic [2:0] {
    OP_INT_DT,
    OP_L1_ERR,
    OP_L2_INT,
    OP_PROP,
    OP_DERIV,
    OP_INERTIA,
    OP_ACCEL,
    OP_SWITCH
  } mul_op_e;

  typedef struct packed {
    logic busy;
    logic div_busy;
    logic out_load;
  } stat_t;

  function automatic logic signed [OPND_W-1:0] sx_op(input q_t v);
    return {v[DW-1], v};
  endfunction

  function automatic logic signed [OPND_W-1:0] zx_op(input uq_t v);
    return {2'b00, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] sx_w(input q_t v);
    return {{(WIDE_W-DW){v[DW-1]}}, v};
  endfunction

  function automatic q_t sat_q(input logic signed [WIDE_W-1:0] v);
    q_t r;
    if (v > WMAX) begin
      r = SMAX;
    end else if (v < WMIN) begin
      r = SMIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ismfc_in_if.sv
// Input channel of the force controller: valid, ready and one control period.
// Depends on ismfc_pkg.
`default_nettype none

interface ismfc_in_if;
  import ismfc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/ismfc_out_if.sv
// Result channel of the force controller: valid, ready and the drive value.
// Depends on ismfc_pkg.
`default_nettype none

interface ismfc_out_if;
  import ismfc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/integral_sliding_mode_force_control.sv
// Top level of the integral sliding-mode force controller: configuration
// registers, sequencer instance and assertions.
// Depends on ismfc_pkg, ismfc_in_if, ismfc_out_if, ismfc_seq and the defines header.
//
// Usage: one transfer on in_i carries one control period (torque, reference
// and its derivatives, time step, load acceleration); exactly one transfer on
// out_o returns the saturated drive value for it. Gains and the boundary
// width are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// in_i.ready is high only when no item is in work; an item adds a division for
// each of the two cases that need one (integral reload when |s| exceeds twice
// the boundary width, and the boundary-layer quotient when |s| is below the
// boundary width). The sequencer runs eight products in turn through the single
// shared multiplier and each division through the one-bit-per-cycle divider.
// The result waits in an output register; the next item is taken meanwhile,
// and its completion holds until that result has gone. Reset clears the
// surface, integral and last error, drops any pending result and restores
// the gain defaults.
`default_nettype none
`include "integral_sliding_mode_force_control_defines.svh"

module integral_sliding_mode_force_control (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [ismfc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [ismfc_pkg::DW-1:0]            cfg_data_i,
  ismfc_in_if.sink                           in_i,
  ismfc_out_if.source                        out_o
);
  import ismfc_pkg::*;

  cfg_t  cfg_d, cfg_q;
  stat_t stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LAMBDA_ONE:     cfg_d.lambda_one     = cfg_data_i[UW-1:0];
        CFG_LAMBDA_TWO:     cfg_d.lambda_two     = cfg_data_i[UW-1:0];
        CFG_PROP_GAIN:      cfg_d.prop_gain      = cfg_data_i;
        CFG_DERIV_GAIN:     cfg_d.deriv_gain     = cfg_data_i;
        CFG_INERTIA_RATIO:  cfg_d.inertia_ratio  = cfg_data_i;
        CFG_BOUNDARY_WIDTH: cfg_d.boundary_width = cfg_data_i[UW-1:0];
        CFG_SWITCH_GAIN:    cfg_d.switch_gain    = cfg_data_i;
        CFG_ACCEL_GAIN:     cfg_d.accel_gain     = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lambda_one     <= UW'(QONE);
      cfg_q.lambda_two     <= UW'(QONE);
      cfg_q.prop_gain      <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.inertia_ratio  <= '0;
      cfg_q.boundary_width <= '0;
      cfg_q.switch_gain    <= '0;
      cfg_q.accel_gain     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ismfc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .out_o  (out_o),
    .stat_o (stat)
  );

  `ISMFC_ASSERT_NXT(a_one_item_in_work, in_i.valid && in_i.ready, !in_i.ready)
  `ISMFC_ASSERT_IMP(a_ready_only_idle, in_i.ready, !stat.busy)
  `ISMFC_ASSERT_IMP(a_div_within_item, stat.div_busy, stat.busy)
  `ISMFC_ASSERT_IMP(a_no_result_overwrite, out_o.valid && !out_o.ready, !stat.out_load)

endmodule

`default_nettype wire

>>> src/ismfc_mul.sv
// Shared Q16.16 multiplier: registered signed product, then floor shift and saturation.
// Depends on ismfc_pkg.
`default_nettype none

module ismfc_mul (
  input  wire                                  clk_i,
  input  wire logic signed [ismfc_pkg::OPND_W-1:0] a_i,
  input  wire logic signed [ismfc_pkg::OPND_W-1:0] b_i,
  output ismfc_pkg::q_t                        qm_o
);
  import ismfc_pkg::*;

  logic signed [2*OPND_W-1:0] prod_full;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   prod_q;

  assign prod_full = a_i * b_i;
  assign prod_d    = prod_full[PROD_W-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign qm_o = sat_q(prod_q[PROD_W-1:FRAC]);

endmodule

`default_nettype wire

>>> src/ismfc_div.sv
// Radix-2 restoring divider for Q16.16 quotients, one quotient bit per cycle,
// with truncation toward zero and saturation. Depends on ismfc_pkg.
`default_nettype none

module ismfc_div (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     start_i,
  input  wire logic signed [ismfc_pkg::OPND_W-1:0] num_i,
  input  wire ismfc_pkg::uq_t                     den_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output ismfc_pkg::q_t                           quo_o
);
  import ismfc_pkg::*;

  logic              busy_d, busy_q;
  logic              done_d, done_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic [WIDE_W-1:0] dvd_d, dvd_q;
  logic [UW-1:0]     rem_d, rem_q;
  uq_t               den_d, den_q;
  logic              neg_d, neg_q;
  logic              zero_d, zero_q;
  logic              nz_d, nz_q;

  logic [OPND_W-1:0] num_abs;
  logic [UW:0]       rem_sh;
  logic [UW:0]       rem_sub;
  logic              fits;
  logic [DW-1:0]     mag_lo;
  logic [DW-1:0]     neg_lo;

  assign num_abs = num_i[OPND_W-1] ? OPND_W'(-num_i) : OPND_W'(num_i);
  assign rem_sh  = {rem_q, dvd_q[WIDE_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign mag_lo  = dvd_q[DW-1:0];
  assign neg_lo  = ~mag_lo + 1'b1;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    nz_d   = nz_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {num_abs[DW-1:0], {FRAC{1'b0}}};
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[OPND_W-1];
      zero_d = (den_i == '0);
      nz_d   = |num_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[WIDE_W-2:0], fits};
      rem_d = fits ? rem_sub[UW-1:0] : rem_sh[UW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    nz_q   <= nz_d;
  end

  always_comb begin
    if (zero_q) begin
      quo_o = nz_q ? (neg_q ? SMIN : SMAX) : '0;
    end else if (neg_q) begin
      quo_o = (dvd_q > ULIM_NEG) ? SMIN : neg_lo;
    end else begin
      quo_o = (dvd_q > ULIM_POS) ? SMAX : mag_lo;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> src/ismfc_seq.sv
// Sequencer and datapath of the force controller: error terms, integral update,
// surface, switching term and output sum over the shared multiplier and divider.
// Depends on ismfc_pkg, ismfc_in_if, ismfc_out_if, ismfc_mul and ismfc_div.
`default_nettype none

module ismfc_seq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire ismfc_pkg::cfg_t  cfg_i,
  ismfc_in_if.sink              in_i,
  ismfc_out_if.source           out_o,
  output ismfc_pkg::stat_t      stat_o
);
  import ismfc_pkg::*;

  state_e   state_d, state_q;
  mul_op_e  op_d, op_q;
  in_item_t in_d, in_q;
  q_t       err_d, err_q;
  q_t       derr_d, derr_q;
  q_t       integral_d, integral_q;
  q_t       surface_d, surface_q;
  q_t       last_err_d, last_err_q;
  q_t       us_d, us_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic     out_valid_d, out_valid_q;
  q_t       out_data_d, out_data_q;

  logic                    in_ready;
  logic                    out_load;
  logic signed [OPND_W-1:0] mul_a, mul_b;
  q_t                      qm;
  logic                    div_start;
  logic signed [OPND_W-1:0] div_num;
  uq_t                     div_den;
  logic                    div_busy, div_done;
  q_t                      div_quo;

  logic signed [OPND_W-1:0] surf_w;
  logic [OPND_W-1:0]        surf_mag;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  qm_acc;
  logic signed [ACC_W-1:0]  acc_n;
  logic signed [WIDE_W-1:0] acc_w;

  ismfc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .qm_o  (qm)
  );

  ismfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    case (op_q)
      OP_INT_DT: begin
        mul_a = sx_op(err_q);
        mul_b = zx_op(in_q.time_step);
      end
      OP_L1_ERR: begin
        mul_a = zx_op(cfg_i.lambda_one);
        mul_b = sx_op(err_q);
      end
      OP_L2_INT: begin
        mul_a = zx_op(cfg_i.lambda_two);
        mul_b = sx_op(integral_q);
      end
      OP_PROP: begin
        mul_a = sx_op(cfg_i.prop_gain);
        mul_b = sx_op(err_q);
      end
      OP_DERIV: begin
        mul_a = sx_op(cfg_i.deriv_gain);
        mul_b = sx_op(derr_q);
      end
      OP_INERTIA: begin
        mul_a = sx_op(cfg_i.inertia_ratio);
        mul_b = sx_op(in_q.ref_accel);
      end
      OP_ACCEL: begin
        mul_a = sx_op(cfg_i.accel_gain);
        mul_b = sx_op(in_q.load_accel);
      end
      OP_SWITCH: begin
        mul_a = sx_op(cfg_i.switch_gain);
        mul_b = sx_op(us_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (op_q)
      OP_INT_DT: acc_base = {{(ACC_W-DW){integral_q[DW-1]}}, integral_q};
      OP_L1_ERR: acc_base = {{(ACC_W-DW){derr_q[DW-1]}}, derr_q};
      OP_PROP:   acc_base = {{(ACC_W-DW){in_q.ref_force[DW-1]}}, in_q.ref_force};
      default:   acc_base = acc_q;
    endcase
  end

  assign qm_acc = {{(ACC_W-DW){qm[DW-1]}}, qm};
  assign acc_n  = (op_q == OP_PROP || op_q == OP_DERIV || op_q == OP_SWITCH) ?
                  acc_base - qm_acc : acc_base + qm_acc;
  assign acc_w  = {{(WIDE_W-ACC_W){acc_n[ACC_W-1]}}, acc_n};

  assign surf_w   = sx_op(surface_q);
  assign surf_mag = surface_q[DW-1] ? OPND_W'(-surf_w) : OPND_W'(surf_w);

  assign div_num = (state_q == S_CHK) ? -sx_op(err_q) : surf_w;
  assign div_den = (state_q == S_CHK) ? cfg_i.lambda_one : cfg_i.boundary_width;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_d       = in_q;
    err_d      = err_q;
    derr_d     = derr_q;
    integral_d = integral_q;
    surface_d  = surface_q;
    last_err_d = last_err_q;
    us_d       = us_q;
    acc_d      = acc_q;
    out_data_d = out_data_q;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          in_d    = in_i.data;
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        err_d   = sat_q(sx_w(in_q.torque_meas) - sx_w(in_q.ref_force));
        derr_d  = sat_q(sx_w(in_q.torque_rate_meas) - sx_w(in_q.ref_rate));
        state_d = S_CHK;
      end
      S_CHK: begin
        if (surf_mag > {1'b0, cfg_i.boundary_width, 1'b0}) begin
          div_start = 1'b1;
          state_d   = S_DIVI;
        end else begin
          if (err_q[DW-1] != last_err_q[DW-1]) begin
            integral_d = '0;
          end
          op_d    = OP_INT_DT;
          state_d = S_MUL;
        end
      end
      S_DIVI: begin
        if (div_done) begin
          integral_d = div_quo;
          op_d       = OP_INT_DT;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        case (op_q)
          OP_INT_DT: begin
            integral_d = sat_q(acc_w);
            op_d       = OP_L1_ERR;
            state_d    = S_MUL;
          end
          OP_L1_ERR: begin
            acc_d   = acc_n;
            op_d    = OP_L2_INT;
            state_d = S_MUL;
          end
          OP_L2_INT: begin
            surface_d = sat_q(acc_w);
            state_d   = S_US;
          end
          OP_PROP: begin
            acc_d   = acc_n;
            op_d    = OP_DERIV;
            state_d = S_MUL;
          end
          OP_DERIV: begin
            acc_d   = acc_n;
            op_d    = OP_INERTIA;
            state_d = S_MUL;
          end
          OP_INERTIA: begin
            acc_d   = acc_n;
            op_d    = OP_ACCEL;
            state_d = S_MUL;
          end
          OP_ACCEL: begin
            acc_d   = acc_n;
            op_d    = OP_SWITCH;
            state_d = S_MUL;
          end
          OP_SWITCH: begin
            if (!out_valid_q || out_o.ready) begin
              out_data_d = sat_q(acc_w);
              out_load   = 1'b1;
              last_err_d = err_q;
              state_d    = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_US: begin
        if (surf_mag < {2'b00, cfg_i.boundary_width}) begin
          div_start = 1'b1;
          state_d   = S_DIVU;
        end else begin
          us_d    = surface_q[DW-1] ? QNEG_ONE : QONE;
          op_d    = OP_PROP;
          state_d = S_MUL;
        end
      end
      S_DIVU: begin
        if (div_done) begin
          us_d    = div_quo;
          op_d    = OP_PROP;
          state_d = S_MUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      surface_q   <= '0;
      last_err_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      integral_q  <= integral_d;
      surface_q   <= surface_d;
      last_err_q  <= last_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    in_q       <= in_d;
    err_q      <= err_d;
    derr_q     <= derr_d;
    us_q       <= us_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.data.drive_out = out_data_q;

  assign stat_o = '{busy: (state_q != S_IDLE), div_busy: div_busy, out_load: out_load};

endmodule

`default_nettype wire

>>> tb/ismfc_drive_checker.sv
// Checker for the integral sliding-mode force controller: follows gain writes and
// transfers, predicts each drive value in fixed point and compares results in order.
// Depends on ismfc_pkg, ismfc_in_if and ismfc_out_if.
`default_nettype none

module ismfc_drive_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [ismfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [ismfc_pkg::DW-1:0]        cfg_data_i,
  ismfc_in_if                            in_mon,
  ismfc_out_if                           out_mon,
  output int                             pending_o,
  output int                             fail_count_o
);
  import ismfc_pkg::*;

  uq_t lam1 = uq_t'(QONE);
  uq_t lam2 = uq_t'(QONE);
  uq_t phi_w = '0;
  q_t  kp = '0;
  q_t  kd = '0;
  q_t  kj = '0;
  q_t  kn = '0;
  q_t  ka = '0;
  q_t  surf = '0;
  q_t  integ = '0;
  q_t  prev_err = '0;
  q_t  drive_q [$];
  int  fails = 0;

  initial begin
    pending_o = 0;
    fail_count_o = 0;
  end

  function automatic q_t clamp32(input longint v);
    q_t r;
    if (v > longint'(SMAX)) begin
      r = SMAX;
    end else if (v < longint'(SMIN)) begin
      r = SMIN;
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // product scaled down by 2^16, rounded toward minus infinity
  function automatic q_t fx_mul(input longint a, input longint b);
    longint p;
    longint q;
    p = a * b;
    if (p >= 0) begin
      q = p / 65536;
    end else begin
      q = -((-p + 65535) / 65536);
    end
    return clamp32(q);
  endfunction

  function automatic q_t fx_div(input longint a, input longint b);
    q_t r;
    if (b == 0) begin
      r = (a > 0) ? SMAX : ((a < 0) ? SMIN : q_t'(0));
    end else begin
      r = clamp32((a * 65536) / b);
    end
    return r;
  endfunction

  function automatic q_t calc_drive(input in_item_t it);
    longint rf;
    longint dt;
    longint phi;
    longint acc;
    q_t     err;
    q_t     derr;
    q_t     s;
    q_t     us;
    rf   = it.ref_force;
    dt   = it.time_step;
    phi  = phi_w;
    err  = clamp32(longint'(it.torque_meas) - rf);
    derr = clamp32(longint'(it.torque_rate_meas) - longint'(it.ref_rate));

    if (mag64(surf) > 2 * phi) begin
      integ = fx_div(-longint'(err), lam1);
    end else if ((err < 0) != (prev_err < 0)) begin
      integ = '0;
    end
    integ = clamp32(longint'(integ) + longint'(fx_mul(err, dt)));

    acc = longint'(derr) + longint'(fx_mul(lam1, err)) + longint'(fx_mul(lam2, integ));
    s = clamp32(acc);

    if (mag64(s) < phi) begin
      us = fx_div(s, phi);
    end else begin
      us = (s < 0) ? QNEG_ONE : QONE;
    end

    acc = -longint'(fx_mul(kp, err))
        - longint'(fx_mul(kd, derr))
        + longint'(fx_mul(kj, it.ref_accel))
        + rf
        + longint'(fx_mul(ka, it.load_accel))
        - longint'(fx_mul(kn, us));

    surf = s;
    prev_err = err;
    return clamp32(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    q_t want;
    if (!rst_ni) begin
      lam1 = uq_t'(QONE);
      lam2 = uq_t'(QONE);
      phi_w = '0;
      kp = '0;
      kd = '0;
      kj = '0;
      kn = '0;
      ka = '0;
      surf = '0;
      integ = '0;
      prev_err = '0;
      drive_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LAMBDA_ONE:     lam1 = cfg_data_i[UW-1:0];
          CFG_LAMBDA_TWO:     lam2 = cfg_data_i[UW-1:0];
          CFG_PROP_GAIN:      kp = q_t'(cfg_data_i);
          CFG_DERIV_GAIN:     kd = q_t'(cfg_data_i);
          CFG_INERTIA_RATIO:  kj = q_t'(cfg_data_i);
          CFG_BOUNDARY_WIDTH: phi_w = cfg_data_i[UW-1:0];
          CFG_SWITCH_GAIN:    kn = q_t'(cfg_data_i);
          CFG_ACCEL_GAIN:     ka = q_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          $error("drive_out: no value expected, got %0d", out_mon.data.drive_out);
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (out_mon.data.drive_out !== want) begin
            $error("drive_out: expected %0d, got %0d", want, out_mon.data.drive_out);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        drive_q.insert(drive_q.size(), calc_drive(in_mon.data));
      end
    end
    pending_o <= drive_q.size();
    fail_count_o <= fails;
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench top for the integral sliding-mode force controller: clock, reset, gain
// writes, directed and random control periods, result back-pressure and verdict.
// Depends on ismfc_pkg, both channel interfaces, the controller and ismfc_drive_checker.
`default_nettype none

module tb_top;
  import ismfc_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 130;
  localparam int PHASE_ITEMS  = 130;
  localparam int PH_DEFAULTS  = 0;
  localparam int PH_DIRECTED  = 1;
  localparam int PH_MAX       = 2;
  localparam int PH_MIN       = 3;
  localparam int PH_COUNT     = 12;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DW-1:0]        cfg_data = '0;
  logic [DW-1:0]        gain_set [8];
  int                   pending;
  int                   fail_cnt;
  int                   idle_cycles = 0;
  bit                   tx_burst = 1'b0;
  bit                   rx_burst = 1'b0;
  q_t                   walk_ref = '0;
  q_t                   walk_off = '0;

  ismfc_in_if  in_ch ();
  ismfc_out_if out_ch ();

  integral_sliding_mode_force_control u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ismfc_drive_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_cnt)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic q_t qv(input int n);
    return q_t'(n <<< FRAC);
  endfunction

  function automatic in_item_t mk(input q_t tq, input q_t dtq, input q_t rf, input q_t drf,
                                  input q_t ddrf, input uq_t dt, input q_t dde);
    in_item_t it;
    it.torque_meas      = tq;
    it.torque_rate_meas = dtq;
    it.ref_force        = rf;
    it.ref_rate         = drf;
    it.ref_accel        = ddrf;
    it.time_step        = dt;
    it.load_accel       = dde;
    return it;
  endfunction

  function automatic q_t rand_q();
    q_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = SMAX;
          1:       v = SMIN;
          2:       v = '0;
          3:       v = QONE;
          default: v = QNEG_ONE;
        endcase
      end
      1, 2:    v = q_t'($urandom);
      3, 4:    v = q_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      default: v = q_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
    return v;
  endfunction

  function automatic uq_t rand_dt();
    uq_t v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = uq_t'($urandom);
      default: v = uq_t'($urandom_range(0, 1 << 12));
    endcase
    return v;
  endfunction

  // mostly a slow trajectory: error wanders about zero so the integral builds up
  function automatic in_item_t rand_item();
    in_item_t it;
    it.torque_rate_meas = rand_q();
    it.ref_rate         = rand_q();
    it.ref_accel        = rand_q();
    it.time_step        = rand_dt();
    it.load_accel       = rand_q();
    if ($urandom_range(0, 9) < 7) begin
      walk_ref = walk_ref + q_t'(int'($urandom_range(0, 1 << 13)) - (1 << 12));
      walk_off = walk_off + q_t'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
      if (walk_off > q_t'(1 << 18) || walk_off < -q_t'(1 << 18)) begin
        walk_off = '0;
      end
      it.ref_force   = walk_ref;
      it.torque_meas = walk_ref + walk_off;
      it.ref_rate    = it.torque_rate_meas - q_t'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
    end else begin
      it.torque_meas = rand_q();
      it.ref_force   = rand_q();
    end
    return it;
  endfunction

  function automatic logic [DW-1:0] rand_ugain();
    uq_t v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1, 2:    v = uq_t'($urandom);
      default: v = uq_t'($urandom_range(0, 8 << FRAC));
    endcase
    return {$urandom_range(0, 1) != 0, v};
  endfunction

  function automatic logic [DW-1:0] rand_sgain();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = SMAX;
      1:       v = SMIN;
      2, 3:    v = $urandom;
      default: v = int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
    endcase
    return v;
  endfunction

  function automatic void pick_gains(input int ph);
    case (ph)
      PH_DIRECTED: begin
        gain_set[CFG_LAMBDA_ONE]     = QONE;
        gain_set[CFG_LAMBDA_TWO]     = '0;
        gain_set[CFG_PROP_GAIN]      = QONE;
        gain_set[CFG_DERIV_GAIN]     = QONE >>> 1;
        gain_set[CFG_INERTIA_RATIO]  = QONE <<< 1;
        gain_set[CFG_BOUNDARY_WIDTH] = QONE;
        gain_set[CFG_SWITCH_GAIN]    = QONE;
        gain_set[CFG_ACCEL_GAIN]     = QNEG_ONE;
      end
      PH_MAX: begin
        gain_set[CFG_LAMBDA_ONE]     = '1;
        gain_set[CFG_LAMBDA_TWO]     = '1;
        gain_set[CFG_PROP_GAIN]      = SMAX;
        gain_set[CFG_DERIV_GAIN]     = SMAX;
        gain_set[CFG_INERTIA_RATIO]  = SMAX;
        gain_set[CFG_BOUNDARY_WIDTH] = '1;
        gain_set[CFG_SWITCH_GAIN]    = SMAX;
        gain_set[CFG_ACCEL_GAIN]     = SMAX;
      end
      PH_MIN: begin
        gain_set[CFG_LAMBDA_ONE]     = '0;
        gain_set[CFG_LAMBDA_TWO]     = '0;
        gain_set[CFG_PROP_GAIN]      = SMIN;
        gain_set[CFG_DERIV_GAIN]     = SMIN;
        gain_set[CFG_INERTIA_RATIO]  = SMIN;
        gain_set[CFG_BOUNDARY_WIDTH] = '0;
        gain_set[CFG_SWITCH_GAIN]    = SMIN;
        gain_set[CFG_ACCEL_GAIN]     = SMIN;
      end
      default: begin
        gain_set[CFG_LAMBDA_ONE]     = rand_ugain();
        gain_set[CFG_LAMBDA_TWO]     = rand_ugain();
        gain_set[CFG_PROP_GAIN]      = rand_sgain();
        gain_set[CFG_DERIV_GAIN]     = rand_sgain();
        gain_set[CFG_INERTIA_RATIO]  = rand_sgain();
        gain_set[CFG_BOUNDARY_WIDTH] = rand_ugain();
        gain_set[CFG_SWITCH_GAIN]    = rand_sgain();
        gain_set[CFG_ACCEL_GAIN]     = rand_sgain();
      end
    endcase
  endfunction

  task automatic write_gains();
    cfg_idx_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= gain_set[r];
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_period(input in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      tx_burst = !tx_burst;
    end
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) begin
        rx_burst = !rx_burst;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PH_COUNT; ph++) begin
      if (ph != PH_DEFAULTS) begin
        pick_gains(ph);
        write_gains();
      end
      case (ph)
        PH_DEFAULTS: begin
          push_period(mk('0, '0, '0, '0, '0, '0, '0));
          push_period(mk(SMAX, SMAX, SMAX, SMAX, SMAX, '1, SMAX));
          push_period(mk(SMIN, SMIN, SMIN, SMIN, SMIN, '0, SMIN));
          push_period(mk(SMAX, SMIN, SMIN, SMAX, SMIN, '1, SMAX));
          push_period(mk(SMIN, SMAX, SMAX, SMIN, SMAX, uq_t'(1), SMIN));
          push_period(mk(qv(1), '0, '0, '0, '0, uq_t'(QONE), '0));
          push_period(mk(qv(-1), '0, '0, '0, '0, uq_t'(QONE), '0));
        end
        PH_DIRECTED: begin
          push_period(mk('0, '0, '0, '0, '0, '0, '0));
          push_period(mk(qv(1), '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(qv(-1), '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(QONE >>> 1, '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(-(QONE >>> 1), '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(qv(3), '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(qv(2), '0, '0, '0, '0, uq_t'(QONE >>> 4), '0));
          push_period(mk(qv(1), qv(1), '0, qv(2), qv(3), uq_t'(QONE), qv(-2)));
          push_period(mk('0, '0, qv(5), '0, '0, uq_t'(QONE), '0));
          push_period(mk(qv(7), '0, '0, '0, '0, '1, '0));
        end
        default: begin
          repeat (PHASE_ITEMS) push_period(rand_item());
        end
      endcase
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while (pending != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/ismfc_pkg.sv
src/ismfc_in_if.sv
src/ismfc_out_if.sv
src/ismfc_mul.sv
src/ismfc_div.sv
src/ismfc_seq.sv
src/integral_sliding_mode_force_control.sv
tb/ismfc_drive_checker.sv
tb/tb_top.sv
